// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PNF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PNF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pnf_pkg.sv -----
// types, constants and helpers of the palettized nibble framebuffer
package pnf_pkg;

   // frame and palette geometry
   localparam int FRAME_WIDTH  = 256;
   localparam int FRAME_HEIGHT = 128;
   localparam int PALETTE_SIZE = 16;

   localparam int PAL_ENTRIES = 16;
   localparam int IDX_W       = 4;
   localparam int COLOR_W     = 32;
   localparam int COORD_W     = 12;

   localparam int ROW_BYTES   = (FRAME_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
   localparam int X_W         = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
   localparam int Y_W         = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int CNT_W       = $clog2(PALETTE_SIZE + 1);

   // opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_FILL  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]         rect_width;
      logic [COORD_W-1:0]         rect_height;
      logic [COLOR_W-1:0]         draw_color;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      logic [15:0]        pixel_rgb565;
      logic [IDX_W-1:0]   pixel_index;
      logic               read_outside;
      logic               palette_overflow;
   } rsp_payload_type;

   // control toward the palette
   typedef struct packed {
      logic               lookup;
      logic [COLOR_W-1:0] color;
      logic [IDX_W-1:0]   rd_index;
   } pal_req_type;

   // status back from the palette
   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [COLOR_W-1:0] rd_color;
      logic               overflow;
   } pal_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FILL_RD,
      ST_FILL_WR
   } state_type;

   // color word to rgb565
   function automatic logic [15:0] to_rgb565(input logic [COLOR_W-1:0] c);
      return {c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

// ----- rtl/pnf_stream_if.sv -----
// valid/ready channel carrying one payload per transaction
interface pnf_stream_if #(parameter type payload_type = logic) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ----- rtl/pnf_pixel_ram.sv -----
// single-port-write, single-port-read ram with registered read data
module pnf_pixel_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/pnf_palette.sv -----
// on-demand palette: parallel color match, append, sticky overflow
`include "assert_macros.svh"

module pnf_palette (
   input  logic                clock,
   input  logic                reset,
   input  pnf_pkg::pal_req_type pal_req,
   output pnf_pkg::pal_rsp_type pal_rsp
);
   import pnf_pkg::*;

   logic [COLOR_W-1:0] colors_ff [PAL_ENTRIES];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               overflow_ff;
   logic               overflow_in;

   logic [PAL_ENTRIES-1:0] match;
   logic                   hit;
   logic [IDX_W-1:0]       hit_index;
   logic                   full;
   logic                   append;

   // compare against every held entry
   always_comb begin
      for (int i = 0; i < PAL_ENTRIES; i++) begin
         match[i] = (i < int'(count_ff)) && (colors_ff[i] == pal_req.color);
      end
   end

   // lowest matching entry wins
   always_comb begin
      hit_index = '0;
      for (int i = PAL_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_index = IDX_W'(i);
         end
      end
   end

   assign hit    = |match;
   assign full   = (count_ff >= CNT_W'(PALETTE_SIZE));
   assign append = pal_req.lookup && !hit && !full;

   // index given for the looked-up color
   always_comb begin
      if (hit) begin
         pal_rsp.index = hit_index;
      end else if (full) begin
         pal_rsp.index = '0;
      end else begin
         pal_rsp.index = IDX_W'(count_ff);
      end
   end

   assign pal_rsp.rd_color = colors_ff[pal_req.rd_index];
   assign pal_rsp.overflow = overflow_ff;

   // count and sticky flag update
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (append) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (pal_req.lookup && !hit && full) begin
         overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // entries read as zero until allocated
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAL_ENTRIES; i++) begin
            colors_ff[i] <= '0;
         end
      end else if (append) begin
         colors_ff[IDX_W'(count_ff)] <= pal_req.color;
      end
   end

   `PNF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(PALETTE_SIZE), "palette count beyond size")
   `PNF_ASSERT_NEXT(a_overflow_sticky, clock, reset, overflow_ff, overflow_ff, "overflow flag cleared")
   `PNF_ASSERT_IMP(a_hit_held, clock, reset, hit, hit_index < IDX_W'(count_ff) || count_ff == CNT_W'(PAL_ENTRIES), "match on unallocated entry")

endmodule

// ----- rtl/palettized_nibble_framebuffer_unit.sv -----
// top level of the palettized 4-bit framebuffer
//
//   channel   dir   handshake       carries
//   req_ch    in    valid/ready     opcode, position, size, color
//   rsp_ch    out   valid/ready     color, rgb565, index, flags
//
// after reset a clearing pass zeroes the pixel ram, one byte a cycle:
// all STORE_BYTES bytes (16384 at 256x128), with req_ch.ready low.
// write and read: accept with ram read in ST_IDLE, then merge or result in ST_EXEC;
// a fill looks up its color, then read-modify-writes the ram per clipped pixel.
// a read waits in ST_EXEC while a previous result is not yet taken.
`include "assert_macros.svh"

module palettized_nibble_framebuffer_unit (
   input logic         clock,
   input logic         reset,
   pnf_stream_if.sink   req_ch,
   pnf_stream_if.source rsp_ch
);
   import pnf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // request decode
   req_payload_type         req;
   logic signed [COORD_W-1:0] req_x;
   logic signed [COORD_W-1:0] req_y;
   logic                    req_inside;
   logic [ADDR_W-1:0]       req_addr;
   logic                    req_fire;

   // clipped fill bounds
   logic signed [COORD_W+1:0] fx_start;
   logic signed [COORD_W+1:0] fx_end_raw;
   logic signed [COORD_W+1:0] fx_end;
   logic signed [COORD_W+1:0] fy_start;
   logic signed [COORD_W+1:0] fy_end_raw;
   logic signed [COORD_W+1:0] fy_end;
   logic                      fill_empty;

   // transaction registers
   logic [1:0]         op_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               inside_ff;
   logic               empty_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [X_W-1:0]     cur_x_ff;
   logic [Y_W-1:0]     cur_y_ff;
   logic [X_W-1:0]     fx0_ff;
   logic [X_W-1:0]     fx_last_ff;
   logic [Y_W-1:0]     fy_last_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff;
   logic [ADDR_W-1:0]  cur_addr;

   // ram and palette links
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;
   pal_req_type       pal_req;
   pal_rsp_type       pal_rsp;

   // control outputs of the state machine
   logic rsp_free;
   logic rsp_load;
   logic fill_step;
   logic fill_done;
   logic [IDX_W-1:0] wr_index;
   logic [IDX_W-1:0] rd_nibble;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   function automatic logic [ADDR_W-1:0] pixel_addr(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
      return ADDR_W'(32'(y) * ROW_BYTES + (32'(x) >> 1));
   endfunction

   assign req      = req_ch.payload;
   assign req_x    = req.pos_x;
   assign req_y    = req.pos_y;
   assign req_fire = req_ch.valid && req_ch.ready;

   // frame check and byte address of the requested pixel
   assign req_inside = (req_x >= 0) && (req_y >= 0) &&
                       (req_x < FRAME_WIDTH) && (req_y < FRAME_HEIGHT);
   assign req_addr   = pixel_addr(req_x[X_W-1:0], req_y[Y_W-1:0]);
   assign cur_addr   = pixel_addr(cur_x_ff, cur_y_ff);

   // rectangle clipped to the frame
   always_comb begin
      fx_start   = (req_x < 0) ? '0 : (COORD_W+2)'(req_x);
      fy_start   = (req_y < 0) ? '0 : (COORD_W+2)'(req_y);
      fx_end_raw = (COORD_W+2)'(req_x) + $signed({2'b00, req.rect_width});
      fy_end_raw = (COORD_W+2)'(req_y) + $signed({2'b00, req.rect_height});
      fx_end     = (fx_end_raw > (COORD_W+2)'(FRAME_WIDTH)) ?
                   (COORD_W+2)'(FRAME_WIDTH) : fx_end_raw;
      fy_end     = (fy_end_raw > (COORD_W+2)'(FRAME_HEIGHT)) ?
                   (COORD_W+2)'(FRAME_HEIGHT) : fy_end_raw;
      fill_empty = (fx_start >= fx_end) || (fy_start >= fy_end);
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign fill_done = (cur_x_ff == fx_last_ff) && (cur_y_ff == fy_last_ff);
   assign rd_nibble = cur_x_ff[0] ? ram_rdata[3:0] : ram_rdata[7:4];
   assign wr_index  = (state_ff == ST_EXEC) ? pal_rsp.index : idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_FILL) begin
               state_in = empty_ff ? ST_IDLE : ST_FILL_RD;
            end else if (op_ff == OP_READ) begin
               if (rsp_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            state_in = fill_done ? ST_IDLE : ST_FILL_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ch.ready     = 1'b0;
      ram_we           = 1'b0;
      ram_waddr        = cur_addr;
      ram_wdata        = cur_x_ff[0] ? {ram_rdata[7:4], wr_index} :
                                       {wr_index, ram_rdata[3:0]};
      ram_re           = 1'b0;
      ram_raddr        = cur_addr;
      pal_req.lookup   = 1'b0;
      pal_req.color    = color_ff;
      pal_req.rd_index = rd_nibble;
      rsp_load         = 1'b0;
      fill_step        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            ram_re       = req_fire && req_inside;
            ram_raddr    = req_addr;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_WRITE: begin
                  pal_req.lookup = inside_ff;
                  ram_we         = inside_ff;
               end
               OP_FILL: begin
                  pal_req.lookup = 1'b1;
               end
               OP_READ: begin
                  rsp_load = rsp_free;
               end
               default: begin
               end
            endcase
         end
         ST_FILL_RD: begin
            ram_re = 1'b1;
         end
         ST_FILL_WR: begin
            ram_we    = 1'b1;
            fill_step = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   // capture the transaction and walk the fill rectangle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req.opcode;
         color_ff   <= req.draw_color;
         inside_ff  <= req_inside;
         empty_ff   <= fill_empty;
         fx0_ff     <= X_W'(fx_start);
         fx_last_ff <= X_W'(fx_end - (COORD_W+2)'(1));
         fy_last_ff <= Y_W'(fy_end - (COORD_W+2)'(1));
         if (req.opcode == OP_FILL) begin
            cur_x_ff <= X_W'(fx_start);
            cur_y_ff <= Y_W'(fy_start);
         end else begin
            cur_x_ff <= req_x[X_W-1:0];
            cur_y_ff <= req_y[Y_W-1:0];
         end
      end else if (fill_step) begin
         if (cur_x_ff == fx_last_ff) begin
            cur_x_ff <= fx0_ff;
            cur_y_ff <= cur_y_ff + Y_W'(1);
         end else begin
            cur_x_ff <= cur_x_ff + X_W'(1);
         end
      end
      if (state_ff == ST_EXEC && op_ff == OP_FILL) begin
         idx_ff <= pal_rsp.index;
      end
   end

   // read result
   always_comb begin
      rsp_payload_in.palette_overflow = pal_rsp.overflow;
      if (inside_ff) begin
         rsp_payload_in.pixel_color  = pal_rsp.rd_color;
         rsp_payload_in.pixel_rgb565 = to_rgb565(pal_rsp.rd_color);
         rsp_payload_in.pixel_index  = rd_nibble;
         rsp_payload_in.read_outside = 1'b0;
      end else begin
         rsp_payload_in.pixel_color  = '0;
         rsp_payload_in.pixel_rgb565 = '0;
         rsp_payload_in.pixel_index  = '0;
         rsp_payload_in.read_outside = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   pnf_pixel_ram #(
      .DATA_W (8),
      .DEPTH  (STORE_BYTES)
   ) u_pixel_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pnf_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .pal_req (pal_req),
      .pal_rsp (pal_rsp)
   );

   `PNF_ASSERT_IMP(a_fill_in_bounds, clock, reset, state_ff == ST_FILL_RD, cur_x_ff >= fx0_ff && cur_x_ff <= fx_last_ff && cur_y_ff <= fy_last_ff, "fill walk left the rectangle")
   `PNF_ASSERT_IMP(a_result_from_read, clock, reset, rsp_load, op_ff == OP_READ && state_ff == ST_EXEC, "result from a non-read transaction")
   `PNF_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid_ff && !rsp_ch.ready, rsp_valid_ff, "pending result dropped")

endmodule
